[rtl/core/pai_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pai_pkg: shared types and constants of the PWM audio interpolator
// Command codes, register map, field widths and page length.
// ----------------------------------------------------------------------------
package pai_pkg;

    // Samples per page; the index counter is sized from it.
    localparam int PAGE_SAMPLES = 64;
    localparam int IDX_W        = (PAGE_SAMPLES > 2) ? $clog2(PAGE_SAMPLES) : 1;

    localparam int SAMPLE_W = 8;
    localparam int DUTY_W   = 9;
    localparam int OFFSET_W = 8;
    localparam int LEDOFF_W = 8;
    localparam int LEDON_W  = 6;    // (sample & 127) >> 1 is at most 63

    localparam int APB_DW = 32;
    localparam int APB_AW = 4;

    // Reset values of the configuration registers
    localparam logic [DUTY_W-1:0]   IDLE_DUTY_RST = 9'd127;
    localparam logic [DUTY_W-1:0]   DUTY_CAP_RST  = 9'd362;
    localparam logic [OFFSET_W-1:0] OFFSET_RST    = 8'd128;
    localparam logic [LEDOFF_W-1:0] LED_OFF_RST   = 8'd255;

    typedef enum logic [1:0] {
        FUNC_TICK = 2'd0,
        FUNC_LOAD = 2'd1,
        FUNC_ARM  = 2'd2,
        FUNC_REST = 2'd3
    } func_t;

    // Register index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_IDLE_DUTY = 2'd0,
        REG_DUTY_CAP  = 2'd1,
        REG_OFFSET    = 2'd2,
        REG_LED_OFF   = 2'd3
    } reg_idx_t;

endpackage

[rtl/core/pai_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pai_if: request and result channels of the PWM audio interpolator
// Valid/ready handshake; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface pai_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    func;
    logic [pai_pkg::SAMPLE_W-1:0]  sample_a;
    logic [pai_pkg::SAMPLE_W-1:0]  sample_b;

    modport source (output valid, output func, output sample_a, output sample_b,
                    input ready);
    modport sink   (input valid, input func, input sample_a, input sample_b,
                    output ready);
endinterface

interface pai_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [pai_pkg::DUTY_W-1:0]  duty;
    logic                        led;
    logic                        page_done;
    logic                        playing;

    modport source (output valid, output duty, output led, output page_done,
                    output playing, input ready);
    modport sink   (input valid, input duty, input led, input page_done,
                    input playing, output ready);
endinterface

[rtl/core/pwm_audio_interpolator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_audio_interpolator: 4x linear interpolating PWM audio player
// Blends sample pairs into PWM duty values, pages through samples, drives
// a voice activity LED.
// ----------------------------------------------------------------------------
// Usage:
//   cmd  - request channel (func, sample_a, sample_b). func selects tick,
//          load sample pair, arm page or rest duty. Send one tick per PWM
//          period; on every fourth tick of a page sample_a carries the
//          next sample.
//   rsp  - one result per request: duty, led, page_done, playing.
//   APB  - four 32-bit registers at 0x0 idle_duty, 0x4 duty_cap,
//          0x8 duty_offset, 0xC led_off_periods. Write only while idle.
// Timing:
//   A request is registered in the input register on acceptance; the
//   state update then writes its result into the output register,
//   which drives rsp.valid. While rsp.ready stays high, one request
//   per cycle is accepted sustained; the state update is a single pass
//   of shift/add, one 9-bit compare and counter decrements.
// Reset: all player state clears, duty reads 127, registers take defaults.
// Stall: when rsp is held off, the output register keeps its result and
//   one more request waits in the input register; cmd.ready then drops.
// ----------------------------------------------------------------------------
module pwm_audio_interpolator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pai_pkg::APB_AW-1:0]    paddr,
    input  logic [pai_pkg::APB_DW-1:0]    pwdata,
    output logic [pai_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    pai_cmd_if.sink                       cmd,
    pai_rsp_if.source                     rsp
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [pai_pkg::DUTY_W-1:0]   idle_duty_reg;
    logic [pai_pkg::DUTY_W-1:0]   duty_cap_reg;
    logic [pai_pkg::OFFSET_W-1:0] duty_offset_reg;
    logic [pai_pkg::LEDOFF_W-1:0] led_off_periods_reg;

    pai_pkg::reg_idx_t reg_idx;
    logic              cfg_wr;

    assign reg_idx = pai_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_duty_reg       <= pai_pkg::IDLE_DUTY_RST;
            duty_cap_reg        <= pai_pkg::DUTY_CAP_RST;
            duty_offset_reg     <= pai_pkg::OFFSET_RST;
            led_off_periods_reg <= pai_pkg::LED_OFF_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                pai_pkg::REG_IDLE_DUTY: idle_duty_reg <= pwdata[pai_pkg::DUTY_W-1:0];
                pai_pkg::REG_DUTY_CAP:  duty_cap_reg  <= pwdata[pai_pkg::DUTY_W-1:0];
                pai_pkg::REG_OFFSET:    duty_offset_reg <= pwdata[pai_pkg::OFFSET_W-1:0];
                pai_pkg::REG_LED_OFF:   led_off_periods_reg <= pwdata[pai_pkg::LEDOFF_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            pai_pkg::REG_IDLE_DUTY: prdata[pai_pkg::DUTY_W-1:0]   = idle_duty_reg;
            pai_pkg::REG_DUTY_CAP:  prdata[pai_pkg::DUTY_W-1:0]   = duty_cap_reg;
            pai_pkg::REG_OFFSET:    prdata[pai_pkg::OFFSET_W-1:0] = duty_offset_reg;
            pai_pkg::REG_LED_OFF:   prdata[pai_pkg::LEDOFF_W-1:0] = led_off_periods_reg;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: input register -> single-pass update -> output register
    // ------------------------------------------------------------------
    logic                          in_valid_reg;
    logic [1:0]                    in_func_reg;
    logic [pai_pkg::SAMPLE_W-1:0]  in_sa_reg;
    logic [pai_pkg::SAMPLE_W-1:0]  in_sb_reg;
    logic                          out_valid_reg;
    logic                          advance;

    // the registered request moves on when the output slot is free or drains
    assign advance   = in_valid_reg & (~out_valid_reg | rsp.ready);
    assign cmd.ready = ~in_valid_reg | advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (cmd.ready)
            in_valid_reg <= cmd.valid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            in_func_reg <= cmd.func;
            in_sa_reg   <= cmd.sample_a;
            in_sb_reg   <= cmd.sample_b;
        end
    end

    // ------------------------------------------------------------------
    // Player state
    // ------------------------------------------------------------------
    logic [pai_pkg::SAMPLE_W-1:0] prev_sample_reg, prev_sample_next;
    logic [pai_pkg::SAMPLE_W-1:0] next_sample_reg, next_sample_next;
    logic [1:0]                   phase_reg, phase_next;
    logic [pai_pkg::IDX_W-1:0]    sample_index_reg, sample_index_next;
    logic                         page_active_reg, page_active_next;
    logic [pai_pkg::DUTY_W-1:0]   duty_reg, duty_next;
    logic                         led_busy_reg, led_busy_next;
    logic [pai_pkg::LEDON_W-1:0]  led_on_count_reg, led_on_count_next;
    logic [pai_pkg::LEDOFF_W-1:0] led_off_count_reg, led_off_count_next;
    logic                         led_reg, led_next;
    logic                         done_next;

    pai_pkg::func_t               func;
    logic [pai_pkg::SAMPLE_W-1:0] blend;
    logic [pai_pkg::DUTY_W-1:0]   duty_sum;
    logic [pai_pkg::DUTY_W-1:0]   cap_m1;
    logic                         wrap;
    logic [pai_pkg::LEDON_W-1:0]  on_cnt;
    logic [pai_pkg::LEDOFF_W-1:0] off_cnt;
    logic                         led_v;

    assign func = pai_pkg::func_t'(in_func_reg);

    // Weighted blend: phase 0 -> a, 1 -> 3a/4+b/4, 2 -> a/2+b/2, 3 -> a/4+3b/4.
    // Each term is truncated separately; the sum never exceeds 8 bits.
    always_comb
    begin
        unique case (phase_reg)
            2'd0: blend = prev_sample_reg;
            2'd1: blend = (prev_sample_reg >> 2) + (prev_sample_reg >> 1)
                        + (next_sample_reg >> 2);
            2'd2: blend = (prev_sample_reg >> 1) + (next_sample_reg >> 1);
            default: blend = (prev_sample_reg >> 2) + (next_sample_reg >> 2)
                           + (next_sample_reg >> 1);
        endcase
    end

    assign duty_sum = {1'b0, blend} + {1'b0, duty_offset_reg};
    assign cap_m1   = duty_cap_reg - 9'd1;    // zero cap wraps to 511
    assign wrap     = (phase_reg == 2'd3);

    // LED sequencer step, applied on each phase wrap
    always_comb
    begin
        on_cnt  = led_on_count_reg;
        off_cnt = led_off_count_reg;
        led_v   = led_reg;
        if (!led_busy_reg)
        begin
            off_cnt = led_off_periods_reg;
            on_cnt  = in_sa_reg[6:1];
            led_v   = 1'b0;
        end
        if (on_cnt != '0)
        begin
            led_v  = 1'b1;
            on_cnt = on_cnt - 1'b1;
        end
        else if (off_cnt != '0)
        begin
            led_v   = 1'b0;
            off_cnt = off_cnt - 1'b1;
        end
    end

    always_comb
    begin
        prev_sample_next   = prev_sample_reg;
        next_sample_next   = next_sample_reg;
        phase_next         = phase_reg;
        sample_index_next  = sample_index_reg;
        page_active_next   = page_active_reg;
        duty_next          = duty_reg;
        led_busy_next      = led_busy_reg;
        led_on_count_next  = led_on_count_reg;
        led_off_count_next = led_off_count_reg;
        led_next           = led_reg;
        done_next          = 1'b0;

        unique case (func)
            pai_pkg::FUNC_TICK:
            begin
                if (page_active_reg)
                begin
                    duty_next  = (duty_sum >= duty_cap_reg) ? cap_m1 : duty_sum;
                    phase_next = phase_reg + 2'd1;
                    if (wrap)
                    begin
                        prev_sample_next = next_sample_reg;
                        next_sample_next = in_sa_reg;
                        if (sample_index_reg ==
                            pai_pkg::IDX_W'(pai_pkg::PAGE_SAMPLES - 1))
                        begin
                            page_active_next  = 1'b0;
                            sample_index_next = '0;
                            done_next         = 1'b1;
                        end
                        else
                            sample_index_next = sample_index_reg + 1'b1;
                        led_on_count_next  = on_cnt;
                        led_off_count_next = off_cnt;
                        led_next           = led_v;
                        led_busy_next      = (on_cnt != '0) || (off_cnt != '0);
                    end
                end
            end
            pai_pkg::FUNC_LOAD:
            begin
                prev_sample_next = in_sa_reg;
                next_sample_next = in_sb_reg;
            end
            pai_pkg::FUNC_ARM:
                page_active_next = 1'b1;
            pai_pkg::FUNC_REST:
                duty_next = idle_duty_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sample_reg   <= '0;
            next_sample_reg   <= '0;
            phase_reg         <= '0;
            sample_index_reg  <= '0;
            page_active_reg   <= 1'b0;
            duty_reg          <= pai_pkg::IDLE_DUTY_RST;
            led_busy_reg      <= 1'b0;
            led_on_count_reg  <= '0;
            led_off_count_reg <= '0;
            led_reg           <= 1'b0;
        end
        else if (advance)
        begin
            prev_sample_reg   <= prev_sample_next;
            next_sample_reg   <= next_sample_next;
            phase_reg         <= phase_next;
            sample_index_reg  <= sample_index_next;
            page_active_reg   <= page_active_next;
            duty_reg          <= duty_next;
            led_busy_reg      <= led_busy_next;
            led_on_count_reg  <= led_on_count_next;
            led_off_count_reg <= led_off_count_next;
            led_reg           <= led_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [pai_pkg::DUTY_W-1:0] out_duty_reg;
    logic                       out_led_reg;
    logic                       out_done_reg;
    logic                       out_playing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_duty_reg    <= duty_next;
            out_led_reg     <= led_next;
            out_done_reg    <= done_next;
            out_playing_reg <= page_active_next;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.duty      = out_duty_reg;
    assign rsp.led       = out_led_reg;
    assign rsp.page_done = out_done_reg;
    assign rsp.playing   = out_playing_reg;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the PWM audio interpolator
// Streams tick, load, arm and rest requests through the valid/ready channels,
// predicts every result with a cycle-free model of the player and compares
// duty, led, page_done and playing in order. Phases change the registers
// over APB and vary sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
    import pai_pkg::*;

    // Cycles without any handshake before the run is declared hung. The
    // slowest legal stretch is a few stalled cycles plus one set of register
    // writes, so this is far above anything a working block needs.
    localparam int STALL_LIMIT  = 1000;
    // Cycles to settle after the last result; longer than the path from acceptance to rsp.valid.
    localparam int DRAIN_CYCLES = 6;
    // Mismatch lines printed before going quiet (counting continues).
    localparam int PRINT_LIMIT  = 40;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        func_t                func;
        logic [SAMPLE_W-1:0]  sample_a;
        logic [SAMPLE_W-1:0]  sample_b;
    } player_cmd_t;

    typedef struct packed {
        logic [DUTY_W-1:0]    duty;
        logic                 led;
        logic                 page_done;
        logic                 playing;
    } player_out_t;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    pai_cmd_if cmd ();
    pai_rsp_if rsp ();

    pwm_audio_interpolator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cmd     (cmd),
        .rsp     (rsp)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the registers and of the player state
    // ------------------------------------------------------------------
    logic [DUTY_W-1:0]    cfg_idle_duty;
    logic [DUTY_W-1:0]    cfg_cap;
    logic [OFFSET_W-1:0]  cfg_offset;
    logic [LEDOFF_W-1:0]  cfg_led_off;

    logic [SAMPLE_W-1:0]  prev_smp;
    logic [SAMPLE_W-1:0]  next_smp;
    logic [1:0]           blend_phase;
    int                   page_pos;       // samples consumed in this page
    logic                 page_live;
    logic [DUTY_W-1:0]    duty_now;
    logic                 led_cycle_busy; // an on/off LED cycle is running
    int                   led_on_left;
    int                   led_off_left;
    logic                 led_now;

    // Request stream and predicted results
    player_cmd_t          cmd_backlog_q[$];
    player_out_t          predicted_outputs_q[$];
    int                   n_issued;
    int                   n_checked;
    int                   mismatches;
    int                   quiet_cycles;
    idle_mode_t           idle_mode;

    // ------------------------------------------------------------------
    // Clock: 2 ns period
    // ------------------------------------------------------------------
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Player prediction: advances the shadow state by one request and
    // returns the result the block must produce for it.
    // ------------------------------------------------------------------
    function automatic player_out_t player_step(player_cmd_t c);
        int          p;
        int          n;
        int          mix;
        int          total;
        player_out_t o;
        p = prev_smp;
        n = next_smp;
        o.page_done = 1'b0;
        case (c.func)
            FUNC_TICK:
            begin
                // A tick while no page plays leaves everything alone
                if (page_live)
                begin
                    // weights 1, 3/4, 1/2, 1/4 on the previous sample,
                    // each term truncated on its own
                    case (blend_phase)
                        2'd0:    mix = p;
                        2'd1:    mix = (p >> 2) + (p >> 1) + (n >> 2);
                        2'd2:    mix = (p >> 1) + (n >> 1);
                        default: mix = (p >> 2) + (n >> 2) + (n >> 1);
                    endcase
                    total = mix + int'(cfg_offset);
                    // cap of zero: cap-1 wraps to 511 in nine bits
                    if (total >= int'(cfg_cap))
                        duty_now = cfg_cap - 9'd1;
                    else
                        duty_now = total[DUTY_W-1:0];
                    blend_phase = blend_phase + 2'd1;
                    if (blend_phase == 2'd0)
                    begin
                        // phase wrap: shift in the sample carried on this tick
                        prev_smp = next_smp;
                        next_smp = c.sample_a;
                        page_pos++;
                        if (page_pos >= PAGE_SAMPLES)
                        begin
                            // page end keeps next_smp, restarts the index
                            page_live   = 1'b0;
                            page_pos    = 0;
                            o.page_done = 1'b1;
                        end
                        // LED: on for (s & 127) >> 1 periods, then off;
                        // a new cycle reads the sample just shifted in
                        if (!led_cycle_busy)
                        begin
                            led_off_left   = cfg_led_off;
                            led_on_left    = c.sample_a[6:1];
                            led_cycle_busy = 1'b1;
                            led_now        = 1'b0;
                        end
                        if (led_on_left != 0)
                        begin
                            led_now = 1'b1;
                            led_on_left--;
                        end
                        else if (led_off_left != 0)
                        begin
                            led_now = 1'b0;
                            led_off_left--;
                        end
                        if (led_on_left == 0 && led_off_left == 0)
                            led_cycle_busy = 1'b0;
                    end
                end
            end
            FUNC_LOAD:
            begin
                prev_smp = c.sample_a;
                next_smp = c.sample_b;
            end
            FUNC_ARM:  page_live = 1'b1;    // phase and index kept as they are
            default:   duty_now  = cfg_idle_duty;
        endcase
        o.duty    = duty_now;
        o.led     = led_now;
        o.playing = page_live;
        return o;
    endfunction

    function automatic void check_field(string what, logic [DUTY_W-1:0] got,
                                        logic [DUTY_W-1:0] want);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, what, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents the backlog one request at a time. A request stays
    // on the bus until accepted; new requests may be held back at random.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : cmd_driver
        player_cmd_t nxt;
        bit          gap;
        if (cmd.valid && cmd.ready)
            predicted_outputs_q.push_back(player_step(player_cmd_t'{
                func_t'(cmd.func), cmd.sample_a, cmd.sample_b}));
        case (idle_mode)
            IDLE_SENDER: gap = ($urandom_range(0, 99) < 46);
            IDLE_BOTH:   gap = ($urandom_range(0, 99) < 6);
            default:     gap = 1'b0;
        endcase
        // Only touch the bus when nothing is waiting on it
        if (rst_n && (!cmd.valid || cmd.ready))
        begin
            if (cmd_backlog_q.size() != 0 && !gap)
            begin
                nxt = cmd_backlog_q.pop_front();
                cmd.valid    <= 1'b1;
                cmd.func     <= nxt.func;
                cmd.sample_a <= nxt.sample_a;
                cmd.sample_b <= nxt.sample_b;
            end
            else
                cmd.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every accepted result is compared with the oldest
    // prediction; ready is dropped at random to stall the block.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : rsp_monitor
        player_out_t want;
        bit          stall;
        if (rsp.valid && rsp.ready)
        begin
            if (predicted_outputs_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= PRINT_LIMIT)
                    $display("%0t: result with nothing pending, expected none, actual duty %0d",
                             $time, rsp.duty);
            end
            else
            begin
                want = predicted_outputs_q.pop_front();
                check_field("duty", rsp.duty, want.duty);
                check_field("led", {8'd0, rsp.led}, {8'd0, want.led});
                check_field("page_done", {8'd0, rsp.page_done}, {8'd0, want.page_done});
                check_field("playing", {8'd0, rsp.playing}, {8'd0, want.playing});
                n_checked++;
            end
        end
        case (idle_mode)
            IDLE_RECEIVER: stall = ($urandom_range(0, 99) < 46);
            IDLE_BOTH:     stall = ($urandom_range(0, 99) < 6);
            default:       stall = 1'b0;
        endcase
        rsp.ready <= !stall;
    end

    // ------------------------------------------------------------------
    // Watchdog: ends a hung run
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watchdog
        if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_cmd(func_t f, logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b);
        cmd_backlog_q.push_back(player_cmd_t'{f, a, b});
        n_issued++;
    endtask

    // Mostly ticks so pages run to their end; loads, arms and rests are
    // scattered in as noise, and the arms restart playback after each page end.
    task automatic add_random_cmds(int count);
        int    r;
        func_t f;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < 82)
                f = FUNC_TICK;
            else if (r < 88)
                f = FUNC_LOAD;
            else if (r < 94)
                f = FUNC_ARM;
            else
                f = FUNC_REST;
            push_cmd(f, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
        end
    endtask

    // APB write: setup cycle, then access cycle. Bits above the register
    // width carry junk, which the block must ignore.
    task automatic reg_write(reg_idx_t idx, logic [DUTY_W-1:0] value);
        logic [APB_DW-1:0] word;
        word = $urandom;
        if (idx == REG_IDLE_DUTY || idx == REG_DUTY_CAP)
            word[DUTY_W-1:0] = value;
        else
            word[OFFSET_W-1:0] = value[OFFSET_W-1:0];
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_IDLE_DUTY: cfg_idle_duty = word[DUTY_W-1:0];
            REG_DUTY_CAP:  cfg_cap       = word[DUTY_W-1:0];
            REG_OFFSET:    cfg_offset    = word[OFFSET_W-1:0];
            default:       cfg_led_off   = word[LEDOFF_W-1:0];
        endcase
        @(negedge clk);
    endtask

    task automatic configure(int idle_v, int cap_v, int offset_v, int led_off_v,
                             idle_mode_t mode);
        reg_write(REG_IDLE_DUTY, DUTY_W'(idle_v));
        reg_write(REG_DUTY_CAP, DUTY_W'(cap_v));
        reg_write(REG_OFFSET, DUTY_W'(offset_v));
        reg_write(REG_LED_OFF, DUTY_W'(led_off_v));
        idle_mode = mode;
    endtask

    // Wait until every issued request has its result, then let the
    // pipeline settle before the registers may change.
    task automatic drain();
        while (n_checked != n_issued)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : main
        cfg_idle_duty  = IDLE_DUTY_RST;
        cfg_cap        = DUTY_CAP_RST;
        cfg_offset     = OFFSET_RST;
        cfg_led_off    = LED_OFF_RST;
        prev_smp       = '0;
        next_smp       = '0;
        blend_phase    = 2'd0;
        page_pos       = 0;
        page_live      = 1'b0;
        duty_now       = 9'd127;
        led_cycle_busy = 1'b0;
        led_on_left    = 0;
        led_off_left   = 0;
        led_now        = 1'b0;
        n_issued       = 0;
        n_checked      = 0;
        mismatches     = 0;
        quiet_cycles   = 0;
        idle_mode      = IDLE_NONE;

        clk          = 1'b0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        cmd.valid    = 1'b0;
        cmd.func     = FUNC_TICK;
        cmd.sample_a = '0;
        cmd.sample_b = '0;
        rsp.ready    = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, reset register values
        push_cmd(FUNC_TICK, 8'hFF, 8'h00);     // tick while idle: outputs hold
        push_cmd(FUNC_REST, 8'h00, 8'hFF);     // idle duty
        push_cmd(FUNC_LOAD, 8'hFF, 8'h00);     // full-scale down ramp
        push_cmd(FUNC_ARM, 8'h00, 8'h00);
        push_cmd(FUNC_ARM, 8'hFF, 8'hFF);      // arm while playing: no change
        push_cmd(FUNC_TICK, 8'h55, 8'hAA);
        push_cmd(FUNC_TICK, 8'hAA, 8'h55);
        push_cmd(FUNC_TICK, 8'h01, 8'hFE);
        push_cmd(FUNC_TICK, 8'hFF, 8'h00);     // wrap: LED on for 63 periods
        push_cmd(FUNC_LOAD, 8'h00, 8'hFF);     // load while playing: up ramp
        push_cmd(FUNC_REST, 8'hFF, 8'h00);     // rest while playing
        push_cmd(FUNC_TICK, 8'hFF, 8'hFF);
        push_cmd(FUNC_TICK, 8'h00, 8'h00);
        push_cmd(FUNC_TICK, 8'h80, 8'h7F);
        push_cmd(FUNC_TICK, 8'h00, 8'hFF);     // wrap with a zero sample
        push_cmd(FUNC_LOAD, 8'hFF, 8'hFF);     // 255 + 128 saturates at cap-1
        push_cmd(FUNC_TICK, 8'h7F, 8'h80);
        push_cmd(FUNC_TICK, 8'hFE, 8'h01);
        push_cmd(FUNC_TICK, 8'h00, 8'h00);
        push_cmd(FUNC_TICK, 8'h80, 8'h00);
        drain();

        // Random phases; page state carries across them, so pages end
        // under several register settings.
        configure(511, 511, 255, 0, IDLE_NONE);     // upper extremes, LED off 0
        add_random_cmds(110);
        drain();

        configure(0, 1, 0, 3, IDLE_SENDER);         // cap 1: duty always 0
        add_random_cmds(110);
        drain();

        configure(300, 0, 200, 255, IDLE_RECEIVER); // cap 0 wraps to 511
        add_random_cmds(110);
        drain();

        configure($urandom_range(0, 511), $urandom_range(1, 511),
                  $urandom_range(0, 255), $urandom_range(0, 15), IDLE_BOTH);
        add_random_cmds(110);
        drain();

        configure($urandom_range(0, 511), $urandom_range(128, 511),
                  $urandom_range(0, 255), $urandom_range(0, 255), IDLE_SENDER);
        add_random_cmds(110);
        drain();

        configure(IDLE_DUTY_RST, DUTY_CAP_RST, OFFSET_RST, 1, IDLE_RECEIVER);
        add_random_cmds(110);
        drain();

        if (predicted_outputs_q.size() != 0)
        begin
            mismatches++;
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, predicted_outputs_q.size());
        end
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
